@@ hw/rtl/tvf32_pkg.sv @@
// shared types, codes and helpers for the typed value to float32 unit
package tvf32_pkg;

    typedef enum logic [3:0] {
        KIND_U8     = 4'd0,
        KIND_S8     = 4'd1,
        KIND_U16    = 4'd2,
        KIND_S16    = 4'd3,
        KIND_U32    = 4'd4,
        KIND_S32    = 4'd5,
        KIND_FLOAT  = 4'd6,
        KIND_DOUBLE = 4'd7
    } t_kind;

    localparam logic [31:0] F32_POS_ZERO = 32'h0000_0000;
    localparam logic [7:0]  F32_EXP_ONES = 8'hFF;

    // round to nearest even given lsb, guard and sticky
    function automatic logic round_up(input logic lsb, input logic guard, input logic sticky);
        return guard & (sticky | lsb);
    endfunction

endpackage

@@ hw/rtl/tvf32_int_conv.sv @@
// integer sign and magnitude to binary32 conversion
module tvf32_int_conv
    import tvf32_pkg::*;
(
    input  logic        i_sign,
    input  logic [31:0] i_mag,
    output logic [31:0] o_bits
);

    logic [4:0]  lead;
    logic [31:0] norm;
    logic [24:0] mant;
    logic        up;
    logic [7:0]  expo;

    always_comb begin
        lead = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (i_mag[k]) begin
                lead = 5'(k);
            end
        end
        norm = i_mag << (5'd31 - lead);
        up   = round_up(norm[8], norm[7], |norm[6:0]);
        mant = {1'b0, norm[31:8]} + {24'd0, up};
        expo = 8'(lead) + 8'd127 + {7'd0, mant[24]};
        if (i_mag == 32'd0) begin
            o_bits = F32_POS_ZERO;
        end else begin
            o_bits = {i_sign, expo, mant[24] ? mant[23:1] : mant[22:0]};
        end
    end

endmodule

@@ hw/rtl/tvf32_dbl_conv.sv @@
// binary64 to binary32 narrowing with round to nearest even
module tvf32_dbl_conv
    import tvf32_pkg::*;
(
    input  logic [63:0] i_dbl,
    output logic [31:0] o_bits
);

    logic        sign;
    logic [10:0] ex;
    logic [51:0] frac;
    logic [52:0] m;
    logic [11:0] e;
    logic [24:0] keep;
    logic        up;
    logic [6:0]  sh;
    logic [52:0] sub_keep;
    logic [52:0] sub_rem;
    logic [52:0] half;
    logic [23:0] sub_res;

    always_comb begin
        sign     = i_dbl[63];
        ex       = i_dbl[62:52];
        frac     = i_dbl[51:0];
        m        = {1'b1, frac};
        e        = {1'b0, ex} - 12'd896;
        up       = round_up(m[29], m[28], |m[27:0]);
        keep     = {1'b0, m[52:29]} + {24'd0, up};
        sh       = 7'((12'd30 - e));
        sub_keep = m >> sh;
        sub_rem  = m & ((53'd1 << sh) - 53'd1);
        half     = 53'd1 << (sh - 7'd1);
        sub_res  = sub_keep[23:0] + {23'd0,
                   (sub_rem > half) || (sub_rem == half && sub_keep[0])};
        if (ex == 11'h7FF) begin
            if (frac == 52'd0) begin
                o_bits = {sign, F32_EXP_ONES, 23'd0};
            end else begin
                o_bits = {sign, F32_EXP_ONES, 1'b1, frac[50:29]};
            end
        end else if (ex == 11'd0) begin
            o_bits = {sign, 31'd0};
        end else if (ex >= 11'd1151) begin
            o_bits = {sign, F32_EXP_ONES, 23'd0};
        end else if (ex >= 11'd897) begin
            if (keep[24] && ex == 11'd1150) begin
                o_bits = {sign, F32_EXP_ONES, 23'd0};
            end else begin
                o_bits = {sign, e[7:0] + {7'd0, keep[24]},
                          keep[24] ? keep[23:1] : keep[22:0]};
            end
        end else if (ex < 11'd873) begin
            o_bits = {sign, 31'd0};
        end else begin
            o_bits = {sign, 7'd0, sub_res};
        end
    end

endmodule

@@ hw/rtl/typed_value_to_float32_unit.sv @@
// top level: registered request, type decode, conversion and result register
// pipeline: input register, then result register; two register stages
// throughput: one request per cycle unless i_stall holds the result, set
// by the single-pass converters between the input and result registers
// reset: synchronous active-low reset clears both valid flags
module typed_value_to_float32_unit
    import tvf32_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_kind,
    input  logic [63:0] i_raw_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_float_bits
);

    logic        r_in_vld;
    logic [3:0]  r_kind;
    logic [63:0] r_raw;
    logic        r_out_vld;
    logic [31:0] r_res;
    logic        adv;
    logic        take;
    logic        isign;
    logic [31:0] imag;
    logic [31:0] ibits;
    logic [31:0] dbits;
    logic [31:0] n_res;

    assign adv     = !r_out_vld || !i_stall;
    assign take    = !r_in_vld || adv;
    assign o_stall = !take;
    assign o_valid = r_out_vld;
    assign o_float_bits = r_res;

    always_comb begin
        isign = 1'b0;
        imag  = 32'd0;
        case (r_kind)
            KIND_U8:  imag = {24'd0, r_raw[7:0]};
            KIND_S8: begin
                isign = r_raw[7];
                imag  = {24'd0, r_raw[7] ? 8'(-r_raw[7:0]) : r_raw[7:0]};
                if (r_raw[7:0] == 8'h80) imag = 32'd128;
            end
            KIND_U16: imag = {16'd0, r_raw[15:0]};
            KIND_S16: begin
                isign = r_raw[15];
                imag  = {16'd0, r_raw[15] ? 16'(-r_raw[15:0]) : r_raw[15:0]};
                if (r_raw[15:0] == 16'h8000) imag = 32'd32768;
            end
            KIND_U32: imag = r_raw[31:0];
            KIND_S32: begin
                isign = r_raw[31];
                imag  = r_raw[31] ? 32'(-r_raw[31:0]) : r_raw[31:0];
            end
            default: imag = 32'd0;
        endcase
    end

    tvf32_int_conv u_int (.i_sign(isign), .i_mag(imag), .o_bits(ibits));
    tvf32_dbl_conv u_dbl (.i_dbl(r_raw), .o_bits(dbits));

    always_comb begin
        case (r_kind)
            KIND_U8, KIND_S8, KIND_U16, KIND_S16, KIND_U32, KIND_S32: n_res = ibits;
            KIND_FLOAT:  n_res = r_raw[31:0];
            KIND_DOUBLE: n_res = dbits;
            default:     n_res = F32_POS_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (take) r_in_vld <= i_valid;
            if (adv)  r_out_vld <= r_in_vld;
        end
        if (take && i_valid) begin
            r_kind <= i_kind;
            r_raw  <= i_raw_bytes;
        end
        if (adv && r_in_vld) r_res <= n_res;
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_float_bits))
        else $error("result changed under stall");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && adv |=> o_valid)
        else $error("request lost between stages");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld && r_out_vld)
        else $error("stall without full pipe");
`endif

endmodule

@@ dv/tb_typed_value_to_float32_unit.sv @@
// self-checking testbench for the typed value to float32 conversion unit
module tb_typed_value_to_float32_unit;
    import tvf32_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_kind;
    logic [63:0] i_raw_bytes;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_float_bits;

    typedef struct {
        logic [3:0]  kind;
        logic [63:0] raw;
    } t_request;

    t_request    pending_requests[$];
    logic [31:0] expected_floats[$];
    int          mismatch_count = 0;
    int          result_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 13;
    int          recv_idle_pct = 70;
    bit          hold_off = 0;
    int          kind_hits[16];

    typed_value_to_float32_unit dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] shift_round_even(logic [63:0] m, int sh);
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        keep = m >> sh;
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
        return keep;
    endfunction

    function automatic logic [31:0] integer_to_single(logic neg, logic [31:0] mag);
        int          e;
        logic [63:0] keep;
        if (mag == 32'd0) return F32_POS_ZERO;
        e = 31;
        while (!mag[e]) e--;
        if (e <= 23) begin
            keep = {32'd0, mag} << (23 - e);
        end else begin
            keep = shift_round_even({32'd0, mag}, e - 23);
            if (keep == (64'd1 << 24)) begin
                keep = keep >> 1;
                e++;
            end
        end
        return {neg, 8'(e + 127), keep[22:0]};
    endfunction

    function automatic logic [31:0] double_to_single(logic [63:0] d);
        logic        sgn;
        logic [10:0] ex;
        logic [51:0] frac;
        logic [63:0] m;
        logic [63:0] keep;
        int          e;
        sgn  = d[63];
        ex   = d[62:52];
        frac = d[51:0];
        if (ex == 11'h7FF) begin
            if (frac == 52'd0) return {sgn, F32_EXP_ONES, 23'd0};
            return {sgn, F32_EXP_ONES, 1'b1, frac[50:29]};
        end
        if (ex == 11'd0) return {sgn, 31'd0};
        m = {11'd0, 1'b1, frac};
        e = int'(ex) - 896;
        if (e >= 255) return {sgn, F32_EXP_ONES, 23'd0};
        if (e >= 1) begin
            keep = shift_round_even(m, 29);
            if (keep == (64'd1 << 24)) begin
                keep = keep >> 1;
                e++;
                if (e >= 255) return {sgn, F32_EXP_ONES, 23'd0};
            end
            return {sgn, 8'(e), keep[22:0]};
        end
        if (30 - e >= 64) return {sgn, 31'd0};
        keep = shift_round_even(m, 30 - e);
        return {sgn, keep[30:0]};
    endfunction

    function automatic logic [31:0] predict_float(t_request r);
        logic [31:0] v;
        case (r.kind)
            KIND_U8:  return integer_to_single(1'b0, {24'd0, r.raw[7:0]});
            KIND_S8: begin
                v = {{24{r.raw[7]}}, r.raw[7:0]};
                return integer_to_single(v[31], v[31] ? -v : v);
            end
            KIND_U16: return integer_to_single(1'b0, {16'd0, r.raw[15:0]});
            KIND_S16: begin
                v = {{16{r.raw[15]}}, r.raw[15:0]};
                return integer_to_single(v[31], v[31] ? -v : v);
            end
            KIND_U32: return integer_to_single(1'b0, r.raw[31:0]);
            KIND_S32: begin
                v = r.raw[31:0];
                return integer_to_single(v[31], v[31] ? -v : v);
            end
            KIND_FLOAT:  return r.raw[31:0];
            KIND_DOUBLE: return double_to_single(r.raw);
            default:     return F32_POS_ZERO;
        endcase
    endfunction

    task automatic report_mismatch(logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch at cycle %0d: float_bits %h, expected %h", cycle_count, got, want);
    endtask

    task automatic add_request(logic [3:0] kind, logic [63:0] raw);
        t_request r;
        r.kind = kind;
        r.raw  = raw;
        pending_requests.push_back(r);
    endtask

    function automatic logic [63:0] random_double();
        logic [63:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: d[62:52] = 11'(896 + $urandom_range(0, 2)) - 11'd1;
            1: d[62:52] = 11'($urandom_range(850, 896));
            2: d[62:52] = 11'($urandom_range(1140, 1152));
            3: d[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'd0;
            4: d[28:0] = $urandom_range(0, 1) ? 29'h1000_0000 : 29'h1FFF_FFFF;
            default: ;
        endcase
        return d;
    endfunction

    function automatic logic [63:0] random_raw(logic [3:0] kind);
        logic [63:0] d;
        d = {$urandom, $urandom};
        if (kind inside {KIND_U32, KIND_S32} && $urandom_range(0, 2) == 0)
            d[7:0] = $urandom_range(0, 1) ? 8'h80 : 8'hFF;
        if (kind == KIND_DOUBLE) d = random_double();
        return d;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) expected_floats.push_back(predict_float('{i_kind, i_raw_bytes}));
            if (pending_requests.size() != 0 && !hold_off
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid     <= 1'b1;
                i_kind      <= pending_requests[0].kind;
                i_raw_bytes <= pending_requests[0].raw;
                kind_hits[pending_requests[0].kind]++;
                void'(pending_requests.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                result_count++;
                if (expected_floats.size() == 0) begin
                    mismatch_count++;
                    $display("unexpected result %h at cycle %0d", o_float_bits, cycle_count);
                end else begin
                    if (o_float_bits !== expected_floats[0])
                        report_mismatch(o_float_bits, expected_floats[0]);
                    void'(expected_floats.pop_front());
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 200000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** typed_value_to_float32_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [3:0] k;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_kind      = 4'd0;
        i_raw_bytes = 64'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_request(KIND_U8, 64'h0);
        add_request(KIND_U8, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(KIND_S8, 64'h80);
        add_request(KIND_S8, 64'h7F);
        add_request(KIND_U16, 64'hFFFF);
        add_request(KIND_S16, 64'h8000);
        add_request(KIND_U32, 64'hFFFF_FFFF);
        add_request(KIND_U32, 64'h0100_0001);
        add_request(KIND_U32, 64'h0100_0003);
        add_request(KIND_S32, 64'h8000_0000);
        add_request(KIND_S32, 64'hFFFF_FFFF);
        add_request(KIND_FLOAT, 64'hFFFF_FFFF_7F80_0001);
        add_request(KIND_DOUBLE, 64'h0);
        add_request(KIND_DOUBLE, 64'h8000_0000_0000_0001);
        add_request(KIND_DOUBLE, 64'h7FF0_0000_0000_0000);
        add_request(KIND_DOUBLE, 64'hFFF0_0000_0000_0000);
        add_request(KIND_DOUBLE, 64'h7FF0_0000_0000_0001);
        add_request(KIND_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_request(KIND_DOUBLE, 64'h47EF_FFFF_F000_0000);
        add_request(KIND_DOUBLE, 64'h47EF_FFFF_EFFF_FFFF);
        add_request(KIND_DOUBLE, 64'h3810_0000_0000_0000);
        add_request(KIND_DOUBLE, 64'h380F_FFFF_F000_0000);
        add_request(KIND_DOUBLE, 64'h3690_0000_0000_0000);
        add_request(4'd8, 64'h1234);
        add_request(4'd15, 64'hFFFF_FFFF_FFFF_FFFF);

        for (int i = 0; i < 850; i++) begin
            k = 4'($urandom_range(0, 9));
            if (k > 4'd7) k = 4'($urandom_range(8, 15));
            add_request(k, random_raw(k));
            if (i == 280) begin
                wait (pending_requests.size() == 0);
                hold_off = 1;
                wait (expected_floats.size() == 0 && !i_valid);
                repeat (5) @(posedge i_clk);
                hold_off = 0;
                send_idle_pct = 70;
                recv_idle_pct = 13;
            end
            if (i == 570) begin
                wait (pending_requests.size() == 0);
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end

        wait (pending_requests.size() == 0 && !i_valid && expected_floats.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("converted %0d requests over all kinds; u8 %0d s32 %0d float %0d double %0d",
                 result_count, kind_hits[0], kind_hits[5], kind_hits[6], kind_hits[7]);
        $display("idle patterns: sender-light, receiver-light, none; one drain pause");
        if (mismatch_count == 0 && expected_floats.size() == 0)
            $display("** typed_value_to_float32_unit: PASSED **");
        else
            $display("** typed_value_to_float32_unit: FAILED **");
        $finish;
    end

endmodule
